// File: sv/mhpq_pkg.sv
// Shared types, codes and widths for the min-heap priority queue.
`timescale 1ns / 1ps

package mhpq_pkg;

    localparam int VAL_W  = 32;
    localparam int CNT_W  = 11;
    localparam int STAT_W = 2;
    localparam int S_TDATA_W = 32;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 48;
    localparam int M_TUSER_W = 3;

    // Opcodes carried in the input tuser.
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_POP    = 1'b1;

    // Status codes of a result.
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    // Control part of the token handed from one level cell to the next.
    typedef struct packed {
        logic vld;
        logic pop;
    } t_tok;

    // Number of heap slots held at one level of a heap of the given capacity.
    function automatic int lvl_size(input int cap, input int lvl);
        int full;
        full = (2 ** (lvl + 1)) - 1;
        if (full <= cap) begin
            return 2 ** lvl;
        end
        return cap - (2 ** lvl) + 1;
    endfunction

endpackage

// File: sv/mhpq_cell.sv
// One level of the heap: its slot memory, and the compare/step logic for a passing token.
`timescale 1ns / 1ps

module mhpq_cell #(
    parameter int LEVEL    = 0,
    parameter int CAPACITY = 1024
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // token from the level above
    input  mhpq_pkg::t_tok                       i_tok,
    input  logic signed [mhpq_pkg::VAL_W-1:0]    i_val,
    input  logic [$clog2(CAPACITY+1)-1:0]        i_pos,
    // token to the level below
    output mhpq_pkg::t_tok                       o_tok,
    output logic signed [mhpq_pkg::VAL_W-1:0]    o_val,
    output logic [$clog2(CAPACITY+1)-1:0]        o_pos,
    output logic                                 o_done,
    // broadcast operation context
    input  logic [$clog2(CAPACITY+1)-1:0]        i_fill,
    input  logic [$clog2($clog2(CAPACITY+1))-1:0] i_depth,
    // direct read of one slot by position
    input  logic                                 i_lrd_vld,
    input  logic [$clog2(CAPACITY+1)-1:0]        i_lrd_pos,
    output logic signed [mhpq_pkg::VAL_W-1:0]    o_lrd_data,
    // sibling-pair read requested by the level above
    input  logic                                 i_prd_vld,
    input  logic [$clog2(CAPACITY+1)-1:0]        i_prd_pos,
    output logic signed [mhpq_pkg::VAL_W-1:0]    o_rd_even,
    output logic signed [mhpq_pkg::VAL_W-1:0]    o_rd_odd,
    // sibling-pair read of the level below
    output logic                                 o_crd_vld,
    output logic [$clog2(CAPACITY+1)-1:0]        o_crd_pos,
    input  logic signed [mhpq_pkg::VAL_W-1:0]    i_ch_even,
    input  logic signed [mhpq_pkg::VAL_W-1:0]    i_ch_odd
);

    localparam int PW    = $clog2(CAPACITY + 1);
    localparam int LW    = $clog2(PW);
    localparam int LSIZE = mhpq_pkg::lvl_size(CAPACITY, LEVEL);
    localparam int H     = (LSIZE + 1) / 2;
    localparam int AW    = $clog2(H);
    localparam logic [LW-1:0] LVL = LW'(LEVEL);

    // phase-1 token state
    logic                              r_busy;
    logic                              r_pop;
    logic signed [mhpq_pkg::VAL_W-1:0] r_val;
    logic [PW-1:0]                     r_pos;

    logic signed [mhpq_pkg::VAL_W-1:0] r_rd_even;
    logic signed [mhpq_pkg::VAL_W-1:0] r_rd_odd;
    logic                              r_lrd_hit;
    logic                              r_lrd_half;

    mhpq_pkg::t_tok                    r_tok;
    logic signed [mhpq_pkg::VAL_W-1:0] r_oval;
    logic [PW-1:0]                     r_opos;
    logic                              r_done;

    logic [PW-1:0]                     w_ins_pos;
    logic                              w_ins_last;
    logic                              w_own_rd;
    logic                              w_lrd_hit;
    logic                              w_rd_en;
    logic [PW-1:0]                     w_rd_pos;
    logic signed [mhpq_pkg::VAL_W-1:0] w_cur;
    logic [PW:0]                       w_lpos;
    logic [PW:0]                       w_rpos;
    logic [PW:0]                       w_fillx;
    logic                              w_lok;
    logic                              w_rok;

    logic                              w_wr_en;
    logic [PW-1:0]                     w_wr_pos;
    logic signed [mhpq_pkg::VAL_W-1:0] w_wr_data;
    logic                              w_wr_half;
    logic                              w_rd_half;
    logic                              w_fwd;
    logic signed [mhpq_pkg::VAL_W-1:0] w_fwd_val;
    logic [PW-1:0]                     w_fwd_pos;
    logic                              w_fin;

    // insert path position at this level: top bits of the target slot
    assign w_ins_pos  = PW'(i_fill >> (i_depth - LVL));
    assign w_ins_last = (i_depth == LVL);

    assign w_own_rd  = i_tok.vld && !i_tok.pop;
    assign w_lrd_hit = i_lrd_vld && ((i_lrd_pos >> LEVEL) == PW'(1));
    assign w_rd_en   = w_own_rd || i_prd_vld || w_lrd_hit;
    assign w_rd_pos  = w_own_rd ? w_ins_pos : (i_prd_vld ? i_prd_pos : i_lrd_pos);
    assign w_rd_half = (LEVEL != 0) && w_rd_pos[0];

    // children of the hole live one level down
    assign o_crd_vld = i_tok.vld && i_tok.pop;
    assign o_crd_pos = {i_pos[PW-2:0], 1'b0};

    assign w_cur   = ((LEVEL != 0) && w_ins_pos[0]) ? r_rd_odd : r_rd_even;
    assign w_lpos  = {r_pos, 1'b0};
    assign w_rpos  = {r_pos, 1'b1};
    assign w_fillx = {1'b0, i_fill};
    assign w_lok   = (w_lpos <= w_fillx);
    assign w_rok   = (w_rpos <= w_fillx);

    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_pos  = r_pos;
        w_wr_data = r_val;
        w_fwd     = 1'b0;
        w_fwd_val = r_val;
        w_fwd_pos = r_pos;
        w_fin     = 1'b0;
        if (r_busy) begin
            if (!r_pop) begin
                w_wr_pos = w_ins_pos;
                if (w_ins_last) begin
                    w_wr_en = 1'b1;
                    w_fin   = 1'b1;
                end else if (r_val < w_cur) begin
                    // keep the smaller value here, push the displaced one down
                    w_wr_en   = 1'b1;
                    w_fwd     = 1'b1;
                    w_fwd_val = w_cur;
                end else begin
                    w_fwd = 1'b1;
                end
            end else begin
                w_wr_en = 1'b1;
                if (!w_lok) begin
                    w_fin = 1'b1;
                end else if (!w_rok) begin
                    if (r_val > i_ch_even) begin
                        w_wr_data = i_ch_even;
                        w_fwd     = 1'b1;
                        w_fwd_pos = w_lpos[PW-1:0];
                    end else begin
                        w_fin = 1'b1;
                    end
                end else if ((r_val < i_ch_even) && (r_val < i_ch_odd)) begin
                    w_fin = 1'b1;
                end else if (i_ch_even < i_ch_odd) begin
                    w_wr_data = i_ch_even;
                    w_fwd     = 1'b1;
                    w_fwd_pos = w_lpos[PW-1:0];
                end else begin
                    // right child smaller or equal: promote the right one
                    w_wr_data = i_ch_odd;
                    w_fwd     = 1'b1;
                    w_fwd_pos = w_rpos[PW-1:0];
                end
            end
        end
    end

    assign w_wr_half = (LEVEL != 0) && w_wr_pos[0];

    generate
        if (H == 1) begin : g_reg
            logic signed [mhpq_pkg::VAL_W-1:0] r_slot_even;
            logic signed [mhpq_pkg::VAL_W-1:0] r_slot_odd;

            always_ff @(posedge i_clk) begin
                if (w_wr_en && !w_wr_half) begin
                    r_slot_even <= w_wr_data;
                end
                if (w_wr_en && w_wr_half) begin
                    r_slot_odd <= w_wr_data;
                end
                if (w_rd_en) begin
                    r_rd_even <= r_slot_even;
                    r_rd_odd  <= r_slot_odd;
                end
            end
        end else begin : g_mem
            logic signed [mhpq_pkg::VAL_W-1:0] r_mem_even [0:H-1];
            logic signed [mhpq_pkg::VAL_W-1:0] r_mem_odd  [0:H-1];
            logic [AW-1:0]                     w_wa;
            logic [AW-1:0]                     w_ra;

            assign w_wa = w_wr_pos[AW:1];
            assign w_ra = w_rd_pos[AW:1];

            always_ff @(posedge i_clk) begin
                if (w_wr_en && !w_wr_half) begin
                    r_mem_even[w_wa] <= w_wr_data;
                end
                if (w_wr_en && w_wr_half) begin
                    r_mem_odd[w_wa] <= w_wr_data;
                end
                if (w_rd_en) begin
                    r_rd_even <= r_mem_even[w_ra];
                    r_rd_odd  <= r_mem_odd[w_ra];
                end
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_tok     <= '0;
            r_done    <= 1'b0;
            r_lrd_hit <= 1'b0;
        end else begin
            r_busy    <= i_tok.vld;
            r_tok.vld <= w_fwd;
            r_tok.pop <= r_pop;
            r_done    <= w_fin;
            r_lrd_hit <= w_lrd_hit;
        end
        r_lrd_half <= w_rd_half;
        if (i_tok.vld) begin
            r_pop <= i_tok.pop;
            r_val <= i_val;
            r_pos <= i_pos;
        end
        r_oval <= w_fwd_val;
        r_opos <= w_fwd_pos;
    end

    assign o_tok      = r_tok;
    assign o_val      = r_oval;
    assign o_pos      = r_opos;
    assign o_done     = r_done;
    assign o_rd_even  = r_rd_even;
    assign o_rd_odd   = r_rd_odd;
    assign o_lrd_data = r_lrd_hit ? (r_lrd_half ? r_rd_odd : r_rd_even) : '0;

endmodule

// File: sv/min_heap_priority_queue_unit.sv
// Min-heap priority queue top level: stream ports, sequencing and the chain of level cells.
`timescale 1ns / 1ps
//
// Usage: each input word on the slave stream is one operation. tuser bit 0 is the
// opcode (0 insert, 1 pop), tdata carries the signed 32-bit value to insert.
// Each accepted word yields exactly one output word on the master stream: tdata
// holds the popped value and the entry count after the operation, tuser holds
// popped_valid and the status (ok, pop while empty, insert while full).
// The heap lives in a chain of cells, one per heap level, each owning that level's
// slots. An operation travels down the chain as a token; at each level a registered
// memory read is followed by a compare and write, so the walk sets the time.
// Insert walks the path to the new slot; pop fetches the root and the last entry,
// then sifts the last entry down from the root.
// Rejected operations (empty pop, full insert) skip the walk and go to the result.
// One operation is in flight at a time; the next word is taken once the result
// is parked in the output register, even while that result is still stalled.
// Reset empties the heap at once (count to zero); slot contents need no clearing.
// A stalled receiver holds the output word; a further result waits inside.

module min_heap_priority_queue_unit #(
    parameter int CAPACITY = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [mhpq_pkg::S_TDATA_W-1:0]    i_s_tdata,   // [31:0] value
    input  logic [mhpq_pkg::S_TUSER_W-1:0]    i_s_tuser,   // [0] opcode
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [mhpq_pkg::M_TDATA_W-1:0]    o_m_tdata,   // [31:0] popped_value,
                                                           // [42:32] entry_count, rest 0
    output logic [mhpq_pkg::M_TUSER_W-1:0]    o_m_tuser    // [0] popped_valid, [2:1] status
);

    localparam int PW = $clog2(CAPACITY + 1);
    localparam int LW = $clog2(PW);
    localparam int VW = mhpq_pkg::VAL_W;
    localparam int CW = mhpq_pkg::CNT_W;
    localparam logic [PW-1:0] CAP_POS = PW'(CAPACITY);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PROOT,
        S_PLAST,
        S_PGET,
        S_RUN,
        S_RES
    } t_state;

    t_state                  r_state;
    logic [PW-1:0]           r_fill;
    logic [PW-1:0]           r_last;
    logic [LW-1:0]           r_depth;
    mhpq_pkg::t_tok          r_tok;
    logic signed [VW-1:0]    r_val;
    logic [PW-1:0]           r_pos;
    logic                    r_lrd_vld;
    logic [PW-1:0]           r_lrd_pos;
    logic signed [VW-1:0]    r_res_pval;
    logic                    r_res_pvalid;
    logic [mhpq_pkg::STAT_W-1:0] r_res_status;
    logic                    r_m_vld;
    logic signed [VW-1:0]    r_m_pval;
    logic                    r_m_pvalid;
    logic [CW-1:0]           r_m_cnt;
    logic [mhpq_pkg::STAT_W-1:0] r_m_status;

    // chain wiring, index k feeds level cell k
    mhpq_pkg::t_tok          w_tok   [0:PW];
    logic signed [VW-1:0]    w_val   [0:PW];
    logic [PW-1:0]           w_pos   [0:PW];
    logic [PW-1:0]           w_done;
    logic signed [VW-1:0]    w_lrd   [0:PW-1];
    logic                    w_crd_vld [0:PW-1];
    logic [PW-1:0]           w_crd_pos [0:PW-1];
    logic signed [VW-1:0]    w_rd_even [0:PW-1];
    logic signed [VW-1:0]    w_rd_odd  [0:PW-1];
    logic signed [VW-1:0]    w_lrd_or;
    logic [CW-1:0]           w_cnt;
    logic                    w_s_acc;
    logic                    w_out_free;
    logic [PW-1:0]           w_fill_inc;

    function automatic logic [LW-1:0] f_msb(input logic [PW-1:0] x);
        logic [LW-1:0] m;
        m = '0;
        for (int i = 0; i < PW; i++) begin
            if (x[i]) begin
                m = LW'(i);
            end
        end
        return m;
    endfunction

    assign w_tok[0] = r_tok;
    assign w_val[0] = r_val;
    assign w_pos[0] = r_pos;

    generate
        for (genvar k = 0; k < PW; k++) begin : g_lvl
            logic                 w_prd_vld;
            logic [PW-1:0]        w_prd_pos;
            logic signed [VW-1:0] w_ch_even;
            logic signed [VW-1:0] w_ch_odd;

            if (k == 0) begin : g_first
                assign w_prd_vld = 1'b0;
                assign w_prd_pos = '0;
            end else begin : g_mid
                assign w_prd_vld = w_crd_vld[k-1];
                assign w_prd_pos = w_crd_pos[k-1];
            end

            // the deepest level never has children in range
            if (k == PW - 1) begin : g_leaf
                assign w_ch_even = '0;
                assign w_ch_odd  = '0;
            end else begin : g_inner
                assign w_ch_even = w_rd_even[k+1];
                assign w_ch_odd  = w_rd_odd[k+1];
            end

            mhpq_cell #(
                .LEVEL   (k),
                .CAPACITY(CAPACITY)
            ) u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_tok     (w_tok[k]),
                .i_val     (w_val[k]),
                .i_pos     (w_pos[k]),
                .o_tok     (w_tok[k+1]),
                .o_val     (w_val[k+1]),
                .o_pos     (w_pos[k+1]),
                .o_done    (w_done[k]),
                .i_fill    (r_fill),
                .i_depth   (r_depth),
                .i_lrd_vld (r_lrd_vld),
                .i_lrd_pos (r_lrd_pos),
                .o_lrd_data(w_lrd[k]),
                .i_prd_vld (w_prd_vld),
                .i_prd_pos (w_prd_pos),
                .o_rd_even (w_rd_even[k]),
                .o_rd_odd  (w_rd_odd[k]),
                .o_crd_vld (w_crd_vld[k]),
                .o_crd_pos (w_crd_pos[k]),
                .i_ch_even (w_ch_even),
                .i_ch_odd  (w_ch_odd)
            );
        end
    endgenerate

    // only the level that owns the requested slot drives nonzero data
    always_comb begin
        w_lrd_or = '0;
        for (int k = 0; k < PW; k++) begin
            w_lrd_or = w_lrd_or | w_lrd[k];
        end
    end

    // count is reported modulo 2^11
    generate
        if (PW >= CW) begin : g_cnt_trunc
            assign w_cnt = r_fill[CW-1:0];
        end else begin : g_cnt_ext
            assign w_cnt = {{(CW - PW){1'b0}}, r_fill};
        end
    endgenerate

    assign o_s_tready = (r_state == S_IDLE);
    assign w_s_acc    = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_m_vld || i_m_tready;
    assign w_fill_inc = r_fill + PW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_fill    <= '0;
            r_tok     <= '0;
            r_lrd_vld <= 1'b0;
            r_m_vld   <= 1'b0;
        end else begin
            r_tok.vld <= 1'b0;
            if (r_m_vld && i_m_tready) begin
                r_m_vld <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_s_acc) begin
                        r_res_pval   <= '0;
                        r_res_pvalid <= 1'b0;
                        r_res_status <= mhpq_pkg::ST_OK;
                        if (i_s_tuser[0] == mhpq_pkg::OP_INSERT) begin
                            if (r_fill == CAP_POS) begin
                                r_res_status <= mhpq_pkg::ST_FULL;
                                r_state      <= S_RES;
                            end else begin
                                // launch the insert down the path to the new slot
                                r_fill    <= w_fill_inc;
                                r_depth   <= f_msb(w_fill_inc);
                                r_tok.vld <= 1'b1;
                                r_tok.pop <= 1'b0;
                                r_val     <= i_s_tdata[VW-1:0];
                                r_state   <= S_RUN;
                            end
                        end else begin
                            if (r_fill == '0) begin
                                r_res_status <= mhpq_pkg::ST_EMPTY;
                                r_state      <= S_RES;
                            end else begin
                                // fetch the root first, then the last entry
                                r_last    <= r_fill;
                                r_fill    <= r_fill - PW'(1);
                                r_lrd_vld <= 1'b1;
                                r_lrd_pos <= PW'(1);
                                r_state   <= S_PROOT;
                            end
                        end
                    end
                end
                S_PROOT: begin
                    r_lrd_pos <= r_last;
                    r_state   <= S_PLAST;
                end
                S_PLAST: begin
                    r_lrd_vld    <= 1'b0;
                    r_res_pval   <= w_lrd_or;
                    r_res_pvalid <= 1'b1;
                    r_state      <= S_PGET;
                end
                S_PGET: begin
                    if (r_fill == '0) begin
                        r_state <= S_RES;
                    end else begin
                        // last entry goes to the root and sifts down
                        r_tok.vld <= 1'b1;
                        r_tok.pop <= 1'b1;
                        r_val     <= w_lrd_or;
                        r_pos     <= PW'(1);
                        r_state   <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (|w_done) begin
                        r_state <= S_RES;
                    end
                end
                S_RES: begin
                    if (w_out_free) begin
                        r_m_vld    <= 1'b1;
                        r_m_pval   <= r_res_pval;
                        r_m_pvalid <= r_res_pvalid;
                        r_m_status <= r_res_status;
                        r_m_cnt    <= w_cnt;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_m_vld;
    assign o_m_tdata  = {{(mhpq_pkg::M_TDATA_W - VW - CW){1'b0}}, r_m_cnt, r_m_pval};
    assign o_m_tuser  = {r_m_status, r_m_pvalid};

    // ---------------------------------------------------------------- checks

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CAP_POS)
        else $error("entry count beyond capacity");

    a_done_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_done))
        else $error("more than one level finished a token");

    a_done_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (|w_done) |-> (r_state == S_RUN))
        else $error("token finished outside of a walk");

    a_fill_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_s_acc |=> $stable(r_fill))
        else $error("entry count moved without an accepted word");

    a_empty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s_acc && (i_s_tuser[0] == mhpq_pkg::OP_POP) && (r_fill == '0))
        |=> ((r_state == S_RES) && (r_res_status == mhpq_pkg::ST_EMPTY)))
        else $error("empty pop not flagged");

    a_pvalid_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_vld && r_m_pvalid) |-> (r_m_status == mhpq_pkg::ST_OK))
        else $error("popped value with error status");

endmodule

// File: bench/testbench.sv
// Self-checking bench for the min-heap priority queue: directed and random operation words.
`timescale 1ns / 1ps

module testbench;
    import mhpq_pkg::*;

    localparam int HEAP_CAP    = 1024;
    localparam int CLK_HALF    = 10;
    localparam int TAIL_CYCLES = 60;   // covers the worst walk plus output stall
    localparam int MAX_REPORTS = 10;

    // Idling profile carried by each word: who is allowed to idle while it is in flight.
    typedef enum logic [1:0] {
        PACE_FREE,
        PACE_SRC,
        PACE_SNK,
        PACE_BOTH
    } pace_t;

    typedef struct {
        logic               op;
        logic signed [31:0] value;
        pace_t              pace;
        bit                 settle;   // hold this word until every result is back
    } op_word_t;

    typedef struct packed {
        logic signed [VAL_W-1:0]  value;
        logic                     valid;
        logic [CNT_W-1:0]         count;
        logic [STAT_W-1:0]        status;
    } heap_result_t;

    // DUT connections
    logic                  i_clk    = 1'b0;
    logic                  i_rst_n  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic [S_TDATA_W-1:0]  s_tdata  = '0;
    logic [S_TUSER_W-1:0]  s_tuser  = '0;
    logic                  m_tready = 1'b0;
    logic                  o_s_tready;
    logic                  o_m_tvalid;
    logic [M_TDATA_W-1:0]  o_m_tdata;
    logic [M_TUSER_W-1:0]  o_m_tuser;

    // Heap image kept by the predictor
    logic signed [31:0]    heap_img [1:HEAP_CAP];
    int unsigned           heap_fill = 0;

    op_word_t              pending_words[$];
    heap_result_t          result_due[$];
    int unsigned           gen_fill = 0;
    pace_t                 cur_pace = PACE_FREE;
    heap_result_t          pred_res;
    heap_result_t          seen_res;
    heap_result_t          want_res;

    int n_ins_ok    = 0;
    int n_ins_full  = 0;
    int n_pop_ok    = 0;
    int n_pop_empty = 0;
    int peak_fill   = 0;
    int n_checked   = 0;
    int n_errors    = 0;
    int n_reported  = 0;

    min_heap_priority_queue_unit #(
        .CAPACITY (HEAP_CAP)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_tdata),     // [31:0] value
        .i_s_tuser  (s_tuser),     // [0] opcode
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (o_m_tdata),   // [31:0] popped_value, [42:32] entry_count, rest 0
        .o_m_tuser  (o_m_tuser)    // [0] popped_valid, [2:1] status
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    function automatic void heap_swap(input int unsigned a, input int unsigned b);
        logic signed [31:0] t;
        t           = heap_img[a];
        heap_img[a] = heap_img[b];
        heap_img[b] = t;
    endfunction

    // Apply one operation to the heap image and return the result word it must produce.
    function automatic heap_result_t heap_apply(input logic op, input logic signed [31:0] v);
        heap_result_t r;
        int unsigned  pos;
        int unsigned  lc;
        int unsigned  rc;
        r        = '0;
        r.status = ST_OK;
        if (op == OP_INSERT) begin
            if (heap_fill >= HEAP_CAP) begin
                r.status = ST_FULL;
            end else begin
                heap_fill++;
                heap_img[heap_fill] = v;
                pos = heap_fill;
                // sift up while strictly below the parent
                while (pos != 1 && heap_img[pos] < heap_img[pos / 2]) begin
                    heap_swap(pos, pos / 2);
                    pos = pos / 2;
                end
            end
        end else begin
            if (heap_fill == 0) begin
                r.status = ST_EMPTY;
            end else begin
                r.value     = heap_img[1];
                r.valid     = 1'b1;
                heap_img[1] = heap_img[heap_fill];
                heap_fill--;
                pos = 1;
                // sift down; stop only on strict order, take the right child on a tie
                while (2 * pos <= heap_fill) begin
                    lc = 2 * pos;
                    rc = lc + 1;
                    if (rc > heap_fill) begin
                        if (heap_img[pos] > heap_img[lc]) begin
                            heap_swap(pos, lc);
                            pos = lc;
                        end else begin
                            break;
                        end
                    end else begin
                        if (heap_img[pos] < heap_img[lc] && heap_img[pos] < heap_img[rc]) begin
                            break;
                        end
                        if (heap_img[lc] < heap_img[rc]) begin
                            heap_swap(pos, lc);
                            pos = lc;
                        end else begin
                            heap_swap(pos, rc);
                            pos = rc;
                        end
                    end
                end
            end
        end
        r.count = CNT_W'(heap_fill);
        return r;
    endfunction

    // Values lean on a narrow band so that ties and equal children show up often.
    function automatic logic signed [31:0] pick_value();
        int k;
        int t;
        k = $urandom_range(0, 99);
        if (k < 40) begin
            t = $urandom_range(0, 12);
            return t - 6;
        end
        if (k < 50) begin
            case ($urandom_range(0, 5))
                0: return 32'sh7FFF_FFFF;
                1: return 32'sh8000_0000;
                2: return 32'sh7FFF_FFFE;
                3: return 32'sh8000_0001;
                4: return 32'sh0000_0000;
                default: return 32'shFFFF_FFFF;
            endcase
        end
        return $signed($urandom());
    endfunction

    task automatic queue_word(input logic op, input logic signed [31:0] v,
                              input pace_t pace, input bit settle);
        op_word_t w;
        w.op     = op;
        w.value  = v;
        w.pace   = pace;
        w.settle = settle;
        pending_words.push_back(w);
        // track occupancy so the fill phase can stop at capacity
        if (op == OP_INSERT) begin
            if (gen_fill < HEAP_CAP) gen_fill++;
        end else if (gen_fill > 0) begin
            gen_fill--;
        end
    endtask

    task automatic queue_mix(input int n, input int ins_pct, input pace_t pace);
        for (int i = 0; i < n; i++) begin
            queue_word(($urandom_range(0, 99) < ins_pct) ? OP_INSERT : OP_POP,
                       pick_value(), pace, i == 0);
        end
    endtask

    // Sender: predict on each accepted word, then present the next one or idle.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && o_s_tready) begin
                pred_res = heap_apply(s_tuser[0], s_tdata);
                result_due.push_back(pred_res);
                case (pred_res.status)
                    ST_FULL:  n_ins_full++;
                    ST_EMPTY: n_pop_empty++;
                    default: begin
                        if (s_tuser[0] == OP_INSERT) n_ins_ok++;
                        else n_pop_ok++;
                    end
                endcase
                if (heap_fill > peak_fill) peak_fill = heap_fill;
            end
            if (!s_tvalid || o_s_tready) begin
                if (pending_words.size() == 0) begin
                    s_tvalid <= 1'b0;
                end else if (pending_words[0].settle && result_due.size() != 0) begin
                    // hold until the block has handed back everything in flight
                    s_tvalid <= 1'b0;
                end else if ($urandom_range(0, 99) <
                             ((pending_words[0].pace == PACE_SRC)  ? 80 :
                              (pending_words[0].pace == PACE_BOTH) ? 28 : 0)) begin
                    s_tvalid <= 1'b0;
                end else begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pending_words[0].value;
                    s_tuser  <= pending_words[0].op;
                    cur_pace <= pending_words[0].pace;
                    pending_words.pop_front();
                end
            end
        end
    end

    // Receiver: check each accepted result word against the oldest prediction.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && m_tready) begin
                seen_res.value  = o_m_tdata[VAL_W-1:0];
                seen_res.count  = o_m_tdata[VAL_W+CNT_W-1:VAL_W];
                seen_res.valid  = o_m_tuser[0];
                seen_res.status = o_m_tuser[STAT_W:1];
                if (result_due.size() == 0) begin
                    n_errors++;
                    if (n_reported < MAX_REPORTS) begin
                        n_reported++;
                        $display("%0t: unexpected result value=%0d valid=%0b count=%0d status=%0d",
                                 $realtime, seen_res.value, seen_res.valid, seen_res.count,
                                 seen_res.status);
                    end
                end else begin
                    want_res = result_due.pop_front();
                    n_checked++;
                    if (seen_res !== want_res || o_m_tdata[M_TDATA_W-1:VAL_W+CNT_W] !== '0) begin
                        n_errors++;
                        if (n_reported < MAX_REPORTS) begin
                            n_reported++;
                            $display("%0t: result %0d want value=%0d valid=%0b count=%0d status=%0d",
                                     $realtime, n_checked, want_res.value, want_res.valid,
                                     want_res.count, want_res.status);
                            $display("%0t: result %0d got  value=%0d valid=%0b count=%0d status=%0d pad=%h",
                                     $realtime, n_checked, seen_res.value, seen_res.valid,
                                     seen_res.count, seen_res.status,
                                     o_m_tdata[M_TDATA_W-1:VAL_W+CNT_W]);
                        end
                    end
                end
            end
            m_tready <= ($urandom_range(0, 99) >=
                         ((cur_pace == PACE_SNK)  ? 80 :
                          (cur_pace == PACE_BOTH) ? 28 : 0));
        end
    end

    initial begin
        // Directed: empty pops, extremes, a run of equal values, pops carrying junk values.
        queue_word(OP_POP,    32'sh0000_0000, PACE_FREE, 1'b0);
        queue_word(OP_POP,    32'shFFFF_FFFF, PACE_FREE, 1'b0);
        queue_word(OP_INSERT, 32'sh7FFF_FFFF, PACE_FREE, 1'b0);
        queue_word(OP_INSERT, 32'sh8000_0000, PACE_FREE, 1'b0);
        queue_word(OP_INSERT, 32'sh0000_0000, PACE_FREE, 1'b0);
        queue_word(OP_INSERT, 32'shFFFF_FFFF, PACE_FREE, 1'b0);
        for (int i = 0; i < 4; i++) queue_word(OP_INSERT, 32'sd5, PACE_FREE, 1'b0);
        queue_word(OP_INSERT, 32'sh5555_5555, PACE_FREE, 1'b0);
        queue_word(OP_INSERT, 32'shAAAA_AAAA, PACE_FREE, 1'b0);
        queue_word(OP_INSERT, 32'sd5, PACE_FREE, 1'b0);
        for (int i = 0; i < 11; i++) begin
            queue_word(OP_POP, (i % 2) ? 32'sh5555_5555 : 32'shAAAA_AAAA, PACE_FREE, 1'b0);
        end
        queue_word(OP_POP, 32'sh7FFF_FFFF, PACE_FREE, 1'b0);

        // Random phases, insert-heavy so the heap climbs toward full.
        queue_mix(150, 85, PACE_FREE);
        queue_mix(150, 85, PACE_SRC);
        queue_mix(150, 80, PACE_SNK);

        // Fill to capacity, push against the full heap, churn at the top, then drain deep.
        queue_word(OP_INSERT, pick_value(), PACE_BOTH, 1'b1);
        while (gen_fill < HEAP_CAP) queue_word(OP_INSERT, pick_value(), PACE_BOTH, 1'b0);
        repeat (3) queue_word(OP_INSERT, pick_value(), PACE_BOTH, 1'b0);
        queue_mix(40, 50, PACE_BOTH);
        queue_mix(60, 0, PACE_SNK);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_words.size() != 0 || s_tvalid || result_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("ran %0d inserts and %0d pops, with %0d pops on empty and %0d inserts on full",
                 n_ins_ok, n_pop_ok, n_pop_empty, n_ins_full);
        $display("heap peaked at %0d entries; %0d results checked, %0d mismatches",
                 peak_fill, n_checked, n_errors);
        if (n_errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #10_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
